### rtl/ibp_pkg.sv
// Shared types, codes and sizes for the image border padder.
package ibp_pkg;

    // Default sizes
    localparam int unsigned MAX_SAMPLES_DEF  = 65536;
    localparam int unsigned MAX_DIM_DEF      = 1024;
    localparam int unsigned MAX_PAD_DEF      = 255;
    localparam int unsigned MAX_CHANNELS_DEF = 4;

    // Field widths
    localparam int unsigned COORD_W  = 11;
    localparam int unsigned PAD_W    = 8;
    localparam int unsigned CHAN_W   = 2;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned CFG_W    = 11;
    // Bordered coordinate arithmetic, with headroom for differences
    localparam int unsigned SUM_W    = COORD_W + 2;
    // Linear source address: row*width, plus column, times channels, plus channel
    localparam int unsigned ROWB_W   = 2 * COORD_W;
    localparam int unsigned PIX_W    = ROWB_W + 1;
    localparam int unsigned ADDR_W   = PIX_W + CNT_W + 1;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_FETCH = 1'b1
    } req_t;

    typedef enum logic {
        BORDER_CONST  = 1'b0,
        BORDER_MIRROR = 1'b1
    } border_mode_t;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_PAD_TOP       = 3'd2,
        REG_PAD_BOTTOM    = 3'd3,
        REG_PAD_LEFT      = 3'd4,
        REG_PAD_RIGHT     = 3'd5,
        REG_CHANNEL_COUNT = 3'd6,
        REG_BORDER_MODE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL,
        ST_ADD,
        ST_SCALE,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        req_t                req_type;
        logic [INDEX_W-1:0]  sample_index;
        logic [SAMPLE_W-1:0] sample_value;
        logic [COORD_W-1:0]  out_col;
        logic [COORD_W-1:0]  out_row;
        logic [CHAN_W-1:0]   out_chan;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel_value;
        logic                in_border;
        logic                out_of_range;
    } out_item_t;

    // Per-axis classification of a bordered coordinate
    typedef struct packed {
        logic over;     // at or beyond the bordered size
        logic in_span;  // within the source span
    } axis_flags_t;

endpackage

### rtl/ibp_ram.sv
// Generic single-port synchronous RAM with registered read.
module ibp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/ibp_axis_map.sv
// Maps one bordered coordinate to its source coordinate over two register stages.
module ibp_axis_map (
    input  logic                        aclk,
    input  logic                        stage1_en,
    input  logic                        stage2_en,
    input  logic [ibp_pkg::COORD_W-1:0] coord,
    input  logic [ibp_pkg::PAD_W-1:0]   lead,
    input  logic [ibp_pkg::COORD_W-1:0] size,
    input  logic [ibp_pkg::PAD_W-1:0]   tail,
    output ibp_pkg::axis_flags_t        flags,
    output logic [ibp_pkg::COORD_W-1:0] src
);

    localparam int unsigned SW = ibp_pkg::SUM_W;

    logic [SW-1:0] p_ext, lead_ext, size_ext, tail_ext, end_pos, total;
    logic [SW-1:0] d_lo_reg, d_hi_reg, d_in_reg;
    logic          lo_reg, hi_reg, over_reg;
    logic [SW-1:0] src_next;
    logic [ibp_pkg::COORD_W-1:0] src_reg;

    assign p_ext    = SW'(coord);
    assign lead_ext = SW'(lead);
    assign size_ext = SW'(size);
    assign tail_ext = SW'(tail);
    assign end_pos  = lead_ext + size_ext;
    assign total    = end_pos + tail_ext;

    // Stage 1: compares and the three candidate distances
    always_ff @(posedge aclk) begin
        if (stage1_en) begin
            over_reg <= (p_ext >= total);
            lo_reg   <= (p_ext < lead_ext);
            hi_reg   <= (p_ext >= end_pos);
            d_lo_reg <= lead_ext - p_ext - SW'(1);
            d_hi_reg <= p_ext - end_pos;
            d_in_reg <= p_ext - lead_ext;
        end
    end

    // Stage 2: mirror with edge repeat, saturating at the far edge
    always_comb begin
        if (lo_reg) begin
            src_next = (d_lo_reg >= size_ext) ? (size_ext - SW'(1)) : d_lo_reg;
        end else if (hi_reg) begin
            src_next = (d_hi_reg >= size_ext) ? '0 : (size_ext - SW'(1) - d_hi_reg);
        end else begin
            src_next = d_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage2_en) begin
            src_reg <= ibp_pkg::COORD_W'(src_next);
        end
    end

    assign flags.over    = over_reg;
    assign flags.in_span = !lo_reg && !hi_reg;
    assign src           = src_reg;

endmodule

### rtl/image_border_padder_core.sv
// Top level of the image border padder: config registers, fetch sequencer, sample store.
//
//  channel  | direction | handshake           | payload
//  s_       | in        | s_valid / s_ready   | s_item  (ibp_pkg::in_item_t)
//  m_       | out       | m_valid / m_ready   | m_item  (ibp_pkg::out_item_t)
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A load item writes the store at its accept edge.
// A fetch item keeps the input closed from its accept edge on, through the border
// mapping (at accept and in ST_SEL), the row multiply, the pixel add and the channel scale,
// the store's registered read and the load of the output register.
// Reset is synchronous and active low; the store is not cleared.
// While the output register holds an untaken item, a finished fetch waits in
// its last state and the input stays closed until the result moves on.
module image_border_padder_core #(
    parameter int unsigned MAX_SAMPLES  = ibp_pkg::MAX_SAMPLES_DEF,
    parameter int unsigned MAX_DIM      = ibp_pkg::MAX_DIM_DEF,
    parameter int unsigned MAX_PAD      = ibp_pkg::MAX_PAD_DEF,
    parameter int unsigned MAX_CHANNELS = ibp_pkg::MAX_CHANNELS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ibp_pkg::in_item_t          s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ibp_pkg::out_item_t         m_item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  ibp_pkg::cfg_idx_t          cfg_index,
    input  logic [ibp_pkg::CFG_W-1:0]  cfg_data
);

    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned CW = ibp_pkg::COORD_W;
    localparam int unsigned PW = ibp_pkg::PAD_W;
    localparam int unsigned NW = ibp_pkg::CNT_W;

    // Configuration registers
    logic [CW-1:0]         width_reg, height_reg;
    logic [PW-1:0]         pad_top_reg, pad_bottom_reg, pad_left_reg, pad_right_reg;
    logic [NW-1:0]         chan_cnt_reg;
    ibp_pkg::border_mode_t mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= CW'(256);
            height_reg     <= CW'(256);
            pad_top_reg    <= '0;
            pad_bottom_reg <= '0;
            pad_left_reg   <= '0;
            pad_right_reg  <= '0;
            chan_cnt_reg   <= NW'(3);
            mode_reg       <= ibp_pkg::BORDER_CONST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ibp_pkg::REG_IMAGE_WIDTH:   width_reg      <= cfg_data;
                ibp_pkg::REG_IMAGE_HEIGHT:  height_reg     <= cfg_data;
                ibp_pkg::REG_PAD_TOP:       pad_top_reg    <= cfg_data[PW-1:0];
                ibp_pkg::REG_PAD_BOTTOM:    pad_bottom_reg <= cfg_data[PW-1:0];
                ibp_pkg::REG_PAD_LEFT:      pad_left_reg   <= cfg_data[PW-1:0];
                ibp_pkg::REG_PAD_RIGHT:     pad_right_reg  <= cfg_data[PW-1:0];
                ibp_pkg::REG_CHANNEL_COUNT: chan_cnt_reg   <= cfg_data[NW-1:0];
                ibp_pkg::REG_BORDER_MODE:
                    mode_reg <= ibp_pkg::border_mode_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    // Effective sizes after clamping to the supported range
    logic [CW-1:0] w_eff, h_eff;
    logic [PW-1:0] pt_eff, pb_eff, pl_eff, pr_eff;
    logic [NW-1:0] ch_eff;

    always_comb begin
        w_eff = width_reg;
        if (width_reg == '0) begin
            w_eff = CW'(1);
        end else if (32'(width_reg) > 32'(MAX_DIM)) begin
            w_eff = CW'(MAX_DIM);
        end
        h_eff = height_reg;
        if (height_reg == '0) begin
            h_eff = CW'(1);
        end else if (32'(height_reg) > 32'(MAX_DIM)) begin
            h_eff = CW'(MAX_DIM);
        end
        ch_eff = chan_cnt_reg;
        if (chan_cnt_reg == '0) begin
            ch_eff = NW'(1);
        end else if (32'(chan_cnt_reg) > 32'(MAX_CHANNELS)) begin
            ch_eff = NW'(MAX_CHANNELS);
        end
        pt_eff = (32'(pad_top_reg) > 32'(MAX_PAD))    ? PW'(MAX_PAD) : pad_top_reg;
        pb_eff = (32'(pad_bottom_reg) > 32'(MAX_PAD)) ? PW'(MAX_PAD) : pad_bottom_reg;
        pl_eff = (32'(pad_left_reg) > 32'(MAX_PAD))   ? PW'(MAX_PAD) : pad_left_reg;
        pr_eff = (32'(pad_right_reg) > 32'(MAX_PAD))  ? PW'(MAX_PAD) : pad_right_reg;
    end

    // Sequencer
    ibp_pkg::state_t state_reg, state_next;
    logic            fetch_acc, load_acc, out_load;
    logic            m_valid_reg, m_valid_next;

    assign fetch_acc = s_valid && s_ready && (s_item.req_type == ibp_pkg::REQ_FETCH);
    assign load_acc  = s_valid && s_ready && (s_item.req_type == ibp_pkg::REQ_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ibp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ibp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (fetch_acc) begin
                    state_next = ibp_pkg::ST_SEL;
                end
            end
            ibp_pkg::ST_SEL:   state_next = ibp_pkg::ST_MUL;
            ibp_pkg::ST_MUL:   state_next = ibp_pkg::ST_ADD;
            ibp_pkg::ST_ADD:   state_next = ibp_pkg::ST_SCALE;
            ibp_pkg::ST_SCALE: state_next = ibp_pkg::ST_READ;
            ibp_pkg::ST_READ:  state_next = ibp_pkg::ST_DONE;
            ibp_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ibp_pkg::ST_IDLE;
                end
            end
            default: state_next = ibp_pkg::ST_IDLE;
        endcase
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Column and row mapping
    ibp_pkg::axis_flags_t x_flags, y_flags;
    logic [CW-1:0]        src_x, src_y;
    logic                 sel_en;

    assign sel_en = (state_reg == ibp_pkg::ST_SEL);

    ibp_axis_map u_map_x (
        .aclk      (aclk),
        .stage1_en (fetch_acc),
        .stage2_en (sel_en),
        .coord     (s_item.out_col),
        .lead      (pl_eff),
        .size      (w_eff),
        .tail      (pr_eff),
        .flags     (x_flags),
        .src       (src_x)
    );

    ibp_axis_map u_map_y (
        .aclk      (aclk),
        .stage1_en (fetch_acc),
        .stage2_en (sel_en),
        .coord     (s_item.out_row),
        .lead      (pt_eff),
        .size      (h_eff),
        .tail      (pb_eff),
        .flags     (y_flags),
        .src       (src_y)
    );

    // Fetch datapath
    logic [ibp_pkg::CHAN_W-1:0] chan_reg;
    logic                       oor_reg, border_reg, rd_en_reg, addr_ok_reg;
    logic [ibp_pkg::ROWB_W-1:0] row_base_reg;
    logic [ibp_pkg::PIX_W-1:0]  pix_reg;
    logic [ibp_pkg::ADDR_W-1:0] addr_reg;
    logic                       oor_now, in_span_now;

    assign oor_now     = x_flags.over || y_flags.over || (NW'(chan_reg) >= ch_eff);
    assign in_span_now = x_flags.in_span && y_flags.in_span;

    always_ff @(posedge aclk) begin
        if (fetch_acc) begin
            chan_reg <= s_item.out_chan;
        end
        // classify the position
        if (state_reg == ibp_pkg::ST_SEL) begin
            oor_reg    <= oor_now;
            border_reg <= !oor_now && !in_span_now;
            rd_en_reg  <= !oor_now && (in_span_now || mode_reg == ibp_pkg::BORDER_MIRROR);
        end
        // row offset in pixels
        if (state_reg == ibp_pkg::ST_MUL) begin
            row_base_reg <= ibp_pkg::ROWB_W'(src_y) * ibp_pkg::ROWB_W'(w_eff);
        end
        // pixel index
        if (state_reg == ibp_pkg::ST_ADD) begin
            pix_reg <= ibp_pkg::PIX_W'(row_base_reg) + ibp_pkg::PIX_W'(src_x);
        end
        // sample address
        if (state_reg == ibp_pkg::ST_SCALE) begin
            addr_reg <= ibp_pkg::ADDR_W'(pix_reg) * ibp_pkg::ADDR_W'(ch_eff)
                        + ibp_pkg::ADDR_W'(chan_reg);
        end
        if (state_reg == ibp_pkg::ST_READ) begin
            addr_ok_reg <= (32'(addr_reg) < 32'(MAX_SAMPLES));
        end
    end

    // Sample store: loads write at accept, fetches read at their computed address
    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [ibp_pkg::SAMPLE_W-1:0] ram_rdata;

    assign ram_we   = load_acc && (32'(s_item.sample_index) < 32'(MAX_SAMPLES));
    assign ram_addr = (state_reg == ibp_pkg::ST_IDLE) ? AW'(s_item.sample_index)
                                                       : AW'(addr_reg);

    ibp_ram #(
        .WIDTH (ibp_pkg::SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_item.sample_value),
        .rdata (ram_rdata)
    );

    // Output register
    ibp_pkg::out_item_t m_item_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg.pixel_value  <= (rd_en_reg && addr_ok_reg) ? ram_rdata : '0;
            m_item_reg.in_border    <= border_reg;
            m_item_reg.out_of_range <= oor_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Checks
    a_fetch_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        fetch_acc |=> (state_reg == ibp_pkg::ST_SEL))
        else $error("fetch accept did not start the sequencer");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while held");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ibp_pkg::ST_IDLE))
        else $error("store written during a fetch");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && oor_reg) |=> (m_item.pixel_value == '0 && !m_item.in_border))
        else $error("out-of-range fetch gave a non-zero item");

    a_const_border: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && border_reg && mode_reg == ibp_pkg::BORDER_CONST)
        |=> (m_item.pixel_value == '0))
        else $error("constant border gave a non-zero sample");

endmodule
